// ===== rtl/hdg_pkg.sv =====
// Shared types, constants and the arctangent table for the compass heading pipeline.
// Used by every module under rtl/; it depends on nothing else.
`default_nettype none

package hdg_pkg;

    localparam int CORDIC_STAGES     = 16;
    localparam int HEADING_FRAC_BITS = 6;

    localparam int TABLE_LEN     = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int ANG_FRAC      = 20;
    localparam int PRESCALE_BITS = 16;
    localparam int DEG_HALF      = 180;
    localparam int DEG_FULL      = 360;

    localparam int AXIS_W = 24;
    localparam int DIFF_W = AXIS_W + 1;
    // prescaled magnitude below 2^40.5, CORDIC gain below 1.65
    localparam int VEC_W  = DIFF_W + PRESCALE_BITS + 2;
    localparam int ANG_W  = 31;
    localparam int HEAD_W = 15;
    localparam int IDX_W  = 5;
    localparam int ROUND_SH = ANG_FRAC - HEADING_FRAC_BITS;

    localparam logic signed [ANG_W-1:0] HALF_ANG   = ANG_W'(DEG_HALF * (2 ** ANG_FRAC));
    localparam logic signed [ANG_W-1:0] FULL_ANG   = ANG_W'(DEG_FULL * (2 ** ANG_FRAC));
    localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(2 ** (ROUND_SH - 1));

    // configuration register indexes
    localparam logic REG_OFFSET_X = 1'b0;
    localparam logic REG_OFFSET_Y = 1'b1;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } hdg_vec_t;

    // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
        logic [26:0] val;
        case (idx)
            5'd0:    val = 27'd47185920;
            5'd1:    val = 27'd27855475;
            5'd2:    val = 27'd14718068;
            5'd3:    val = 27'd7471121;
            5'd4:    val = 27'd3750058;
            5'd5:    val = 27'd1876857;
            5'd6:    val = 27'd938658;
            5'd7:    val = 27'd469357;
            5'd8:    val = 27'd234682;
            5'd9:    val = 27'd117342;
            5'd10:   val = 27'd58671;
            5'd11:   val = 27'd29335;
            5'd12:   val = 27'd14668;
            5'd13:   val = 27'd7334;
            5'd14:   val = 27'd3667;
            5'd15:   val = 27'd1833;
            5'd16:   val = 27'd917;
            5'd17:   val = 27'd458;
            5'd18:   val = 27'd229;
            5'd19:   val = 27'd115;
            5'd20:   val = 27'd57;
            5'd21:   val = 27'd29;
            5'd22:   val = 27'd14;
            5'd23:   val = 27'd7;
            default: val = 27'd0;
        endcase
        return signed'({{(ANG_W-27){1'b0}}, val});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hdg_front.sv =====
// Front stage: offset removal, prescale and left half plane fold into the CORDIC vector.
// Depends on hdg_pkg.
`default_nettype none

module hdg_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ld,
    input  wire logic                         in_valid,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   raw_x,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   raw_y,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   off_x,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   off_y,
    output      logic                         out_valid,
    output      hdg_pkg::hdg_vec_t            out_vec
);
    import hdg_pkg::*;

    logic signed [DIFF_W-1:0] sx, sy, ox, oy;
    logic signed [DIFF_W-1:0] dx, dy, ndx, ndy;
    logic                     valid_reg;
    hdg_vec_t                 vec_reg, vec_next;

    always_comb begin
        sx  = signed'({raw_x[AXIS_W-1], raw_x});
        sy  = signed'({raw_y[AXIS_W-1], raw_y});
        ox  = signed'({off_x[AXIS_W-1], off_x});
        oy  = signed'({off_y[AXIS_W-1], off_y});
        dx  = sx - ox;
        dy  = sy - oy;
        ndx = ox - sx;
        ndy = oy - sy;
        vec_next.zero = (raw_x == off_x) && (raw_y == off_y);
        if (dx[DIFF_W-1]) begin
            vec_next.x = VEC_W'(ndx) <<< PRESCALE_BITS;
            vec_next.y = VEC_W'(ndy) <<< PRESCALE_BITS;
            vec_next.z = HALF_ANG;
        end else begin
            vec_next.x = VEC_W'(dx) <<< PRESCALE_BITS;
            vec_next.y = VEC_W'(dy) <<< PRESCALE_BITS;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ld) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== rtl/hdg_cordic_stage.sv =====
// One registered CORDIC vectoring stage; the stage index selects shift and table entry.
// Depends on hdg_pkg.
`default_nettype none

module hdg_cordic_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ld,
    input  wire logic [hdg_pkg::IDX_W-1:0]  stage_idx,
    input  wire logic                       in_valid,
    input  wire hdg_pkg::hdg_vec_t          in_vec,
    output      logic                       out_valid,
    output      hdg_pkg::hdg_vec_t          out_vec
);
    import hdg_pkg::*;

    logic signed [VEC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0] ang;
    logic                    valid_reg;
    hdg_vec_t                vec_reg, vec_next;

    always_comb begin
        xs  = in_vec.x >>> stage_idx;
        ys  = in_vec.y >>> stage_idx;
        ang = atan_deg(stage_idx);
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[VEC_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ang;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ld) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== rtl/hdg_finish.sv =====
// Back end: wraps the angle into one turn, rounds to the output format, holds the result.
// Depends on hdg_pkg.
`default_nettype none

module hdg_finish (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        ld_wrap,
    input  wire logic                        ld_out,
    input  wire logic                        in_valid,
    input  wire hdg_pkg::hdg_vec_t           in_vec,
    output      logic                        wrap_valid,
    output      logic                        out_valid,
    output      logic [hdg_pkg::HEAD_W-1:0]  heading
);
    import hdg_pkg::*;

    logic signed [ANG_W-1:0] total_reg, total_next;
    logic signed [ANG_W-1:0] sum;
    logic [ANG_W-1:0]        h;
    logic                    at_full;
    logic                    wrap_valid_reg, out_valid_reg;
    logic [HEAD_W-1:0]       heading_reg, heading_next;

    always_comb begin
        if (in_vec.zero) begin
            total_next = '0;
        end else if (in_vec.z < 0) begin
            total_next = in_vec.z + FULL_ANG;
        end else if (in_vec.z >= FULL_ANG) begin
            total_next = in_vec.z - FULL_ANG;
        end else begin
            total_next = in_vec.z;
        end
    end

    always_comb begin
        sum     = total_reg + ROUND_HALF;
        h       = unsigned'(sum) >> ROUND_SH;
        at_full = total_reg >= (FULL_ANG - ROUND_HALF);
        heading_next = at_full ? '0 : h[HEAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ld_wrap) begin
                wrap_valid_reg <= in_valid;
            end
            if (ld_out) begin
                out_valid_reg <= wrap_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_wrap) begin
            total_reg <= total_next;
        end
        if (ld_out) begin
            heading_reg <= heading_next;
        end
    end

    assign wrap_valid = wrap_valid_reg;
    assign out_valid  = out_valid_reg;
    assign heading    = heading_reg;

endmodule

`default_nettype wire

// ===== rtl/magnetometer_heading_atan2_top.sv =====
// Compass heading top level: configuration registers, pipeline stall chain, assertions.
// Depends on hdg_pkg, hdg_front, hdg_cordic_stage and hdg_finish.
//
// Usage:
//   Input channel s_valid/s_ready carries one raw x/y magnetometer pair per transfer
//   (24-bit two's complement patterns). Output channel m_valid/m_ready carries the
//   heading in degrees with 6 fraction bits, 0 up to 23039.
//   cfg_wr_en/cfg_index/cfg_wdata write the hard-iron offsets (index 0: x, 1: y);
//   write them only while the pipeline holds no item.
//   Pipeline: front stage, 16 CORDIC stages, wrap stage, output register.
//   Throughput: one item per cycle while the output is not stalled by m_ready; each
//   CORDIC stage is one registered add/subtract of the vector and angle.
//   Reset (aresetn low, synchronous) empties every stage and clears both offsets.
//   When m_ready is low the result holds; earlier stages keep filling their empty
//   slots, so s_ready drops only once every stage holds an item.
`default_nettype none

module magnetometer_heading_atan2_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   s_raw_x,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   s_raw_y,
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [hdg_pkg::HEAD_W-1:0]   m_heading_deg,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [hdg_pkg::AXIS_W-1:0]   cfg_wdata
);
    import hdg_pkg::*;

    logic [AXIS_W-1:0] off_x_reg, off_y_reg;

    // slot 0: front, slots 1..NUM_STAGES: CORDIC, last slot: wrap stage
    logic     valid [NUM_STAGES+2];
    logic     ld    [NUM_STAGES+2];
    hdg_vec_t vec   [NUM_STAGES+1];
    logic     ld_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg <= '0;
            off_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_wdata;
                REG_OFFSET_Y: off_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign ld_out = !m_valid || m_ready;
    assign ld[NUM_STAGES+1] = !valid[NUM_STAGES+1] || ld_out;
    for (genvar k = 0; k <= NUM_STAGES; k++) begin : g_ld
        assign ld[k] = !valid[k] || ld[k+1];
    end
    assign s_ready = ld[0];

    hdg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld        (ld[0]),
        .in_valid  (s_valid),
        .raw_x     (s_raw_x),
        .raw_y     (s_raw_y),
        .off_x     (off_x_reg),
        .off_y     (off_y_reg),
        .out_valid (valid[0]),
        .out_vec   (vec[0])
    );

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        hdg_cordic_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ld        (ld[k+1]),
            .stage_idx (IDX_W'(k)),
            .in_valid  (valid[k]),
            .in_vec    (vec[k]),
            .out_valid (valid[k+1]),
            .out_vec   (vec[k+1])
        );
    end

    hdg_finish u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld_wrap    (ld[NUM_STAGES+1]),
        .ld_out     (ld_out),
        .in_valid   (valid[NUM_STAGES]),
        .in_vec     (vec[NUM_STAGES]),
        .wrap_valid (valid[NUM_STAGES+1]),
        .out_valid  (m_valid),
        .heading    (m_heading_deg)
    );

    // input stalls only when the output is stalled
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    // stalled output: the heading holds until it transfers
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_heading_deg)))
        else $error("heading changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_heading_deg) < (DEG_FULL << HEADING_FRAC_BITS)))
        else $error("heading out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== tb/magnetometer_heading_atan2_top_tb.sv =====
// Testbench for magnetometer_heading_atan2_top: directed and random x/y pairs over several
// hard-iron offset settings, each heading checked against a CORDIC predictor in the scoreboard.
// Depends on hdg_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

class heading_scoreboard;
    localparam int STAGES = (hdg_pkg::CORDIC_STAGES < 24) ? hdg_pkg::CORDIC_STAGES : 24;
    localparam int SHIFT  = hdg_pkg::ANG_FRAC - hdg_pkg::HEADING_FRAC_BITS;

    longint atan_tab[24];
    longint off_x;
    longint off_y;
    logic [hdg_pkg::HEAD_W-1:0] heading_q[$];
    int errors;

    function new();
        atan_tab = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                     938658, 469357, 234682, 117342, 58671, 29335,
                     14668, 7334, 3667, 1833, 917, 458,
                     229, 115, 57, 29, 14, 7};
        off_x  = 0;
        off_y  = 0;
        errors = 0;
    endfunction

    function longint widen(logic [hdg_pkg::AXIS_W-1:0] v);
        return {{(64-hdg_pkg::AXIS_W){v[hdg_pkg::AXIS_W-1]}}, v};
    endfunction

    function void set_offset(logic idx, logic [hdg_pkg::AXIS_W-1:0] value);
        if (idx == hdg_pkg::REG_OFFSET_X) begin
            off_x = widen(value);
        end else begin
            off_y = widen(value);
        end
    endfunction

    function logic [hdg_pkg::HEAD_W-1:0] heading_of(logic [hdg_pkg::AXIS_W-1:0] rx,
                                                     logic [hdg_pkg::AXIS_W-1:0] ry);
        longint dx, dy, vx, vy, xs, ys, ang, full;
        longint unsigned h;
        dx   = widen(rx) - off_x;
        dy   = widen(ry) - off_y;
        full = longint'(360) << hdg_pkg::ANG_FRAC;
        ang  = 0;
        if (dx == 0 && dy == 0) begin
            return '0;
        end
        vx = dx <<< hdg_pkg::PRESCALE_BITS;
        vy = dy <<< hdg_pkg::PRESCALE_BITS;
        // left half plane: rotate by 180 first
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = longint'(180) << hdg_pkg::ANG_FRAC;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + ys;
                vy  = vy - xs;
                ang = ang + atan_tab[i];
            end else begin
                vx  = vx - ys;
                vy  = vy + xs;
                ang = ang - atan_tab[i];
            end
        end
        if (ang < 0) begin
            ang = ang + full;
        end
        if (ang >= full) begin
            ang = ang - full;
        end
        h = (longint'(ang) + ((SHIFT > 0) ? (longint'(1) << (SHIFT - 1)) : 0)) >> SHIFT;
        if (h >= (longint'(360) << hdg_pkg::HEADING_FRAC_BITS)) begin
            h = 0;
        end
        return h[hdg_pkg::HEAD_W-1:0];
    endfunction

    function void note_input(logic [hdg_pkg::AXIS_W-1:0] rx, logic [hdg_pkg::AXIS_W-1:0] ry);
        heading_q.push_back(heading_of(rx, ry));
    endfunction

    function void check_result(logic [hdg_pkg::HEAD_W-1:0] actual);
        logic [hdg_pkg::HEAD_W-1:0] want;
        if (heading_q.size() == 0) begin
            $display("%0t: unexpected heading transfer, actual %0d", $time, actual);
            errors++;
            return;
        end
        want = heading_q.pop_front();
        if (actual !== want) begin
            $display("%0t: heading mismatch, expected %0d actual %0d", $time, want, actual);
            errors++;
        end
    endfunction

    function int pending();
        return heading_q.size();
    endfunction
endclass

module magnetometer_heading_atan2_top_tb;
    import hdg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [AXIS_W-1:0]   s_raw_x;
    logic [AXIS_W-1:0]   s_raw_y;
    logic                m_valid;
    logic                m_ready;
    logic [HEAD_W-1:0]   m_heading_deg;
    logic                cfg_wr_en;
    logic                cfg_index;
    logic [AXIS_W-1:0]   cfg_wdata;

    heading_scoreboard sb;
    logic calm;
    int   stall_cycles;

    magnetometer_heading_atan2_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_x       (s_raw_x),
        .s_raw_y       (s_raw_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading_deg (m_heading_deg),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_raw_x, s_raw_y);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_heading_deg);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog expired, %0d headings pending", $time, sb.pending());
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic send_pair(input logic [AXIS_W-1:0] rx, input logic [AXIS_W-1:0] ry);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_x <= rx;
        s_raw_y <= ry;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic set_offsets(input logic [AXIS_W-1:0] ox, input logic [AXIS_W-1:0] oy);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OFFSET_X;
        cfg_wdata <= ox;
        @(posedge aclk);
        cfg_index <= REG_OFFSET_Y;
        cfg_wdata <= oy;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_offset(REG_OFFSET_X, ox);
        sb.set_offset(REG_OFFSET_Y, oy);
    endtask

    // axis value at, near or far from the offset
    function automatic logic [AXIS_W-1:0] near_axis(input longint off);
        logic [AXIS_W-1:0] base;
        base = off[AXIS_W-1:0];
        case ($urandom_range(0, 3))
            0:       return base;
            1:       return base + AXIS_W'($urandom_range(0, 64)) - AXIS_W'(32);
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int n, input bit hold_mid);
        for (int i = 0; i < n; i++) begin
            if (hold_mid && i == n / 2) begin
                settle();
            end
            send_pair(near_axis(sb.off_x), near_axis(sb.off_y));
        end
    endtask

    initial begin
        sb           = new();
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_raw_x      = '0;
        s_raw_y      = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_OFFSET_X;
        cfg_wdata    = '0;
        calm         = 1'b0;
        stall_cycles = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset offsets
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000001, 24'h000000);
        send_pair(24'h000000, 24'h000001);
        send_pair(24'hFFFFFF, 24'h000000);
        send_pair(24'h000000, 24'hFFFFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h400000, 24'hFFFFFF);
        send_pair(24'h400000, 24'h000001);
        send_pair(24'hC00000, 24'h000001);
        send_pair(24'hC00000, 24'hFFFFFF);
        send_pair(24'h000005, 24'h000003);
        send_pair(24'hAAAAAA, 24'h555555);
        send_pair(24'h555555, 24'hAAAAAA);
        settle();
        // extreme offsets give the widest axis differences
        set_offsets(24'h800000, 24'h7FFFFF);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h000000, 24'h000000);
        settle();
        // nonzero readings that cancel against the offsets
        set_offsets(24'h123456, 24'hFFFFFB);
        send_pair(24'h123456, 24'hFFFFFB);
        send_pair(24'h123457, 24'hFFFFFB);
        settle();

        // random phases
        set_offsets(AXIS_W'($urandom), AXIS_W'($urandom));
        run_phase(PHASE_ITEMS, 1'b0);
        settle();
        set_offsets(24'h7FFFFF, 24'h7FFFFF);
        run_phase(PHASE_ITEMS, 1'b0);
        settle();
        set_offsets(24'h800000, 24'h800000);
        run_phase(PHASE_ITEMS, 1'b0);
        settle();
        set_offsets(24'h000000, 24'h000000);
        calm = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        calm = 1'b0;
        settle();
        set_offsets(AXIS_W'($urandom), AXIS_W'($urandom));
        run_phase(PHASE_ITEMS, 1'b1);
        settle();
        set_offsets(24'h800000, 24'h7FFFFF);
        run_phase(PHASE_ITEMS, 1'b0);

        settle();
        repeat (25) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/hdg_pkg.sv
rtl/hdg_front.sv
rtl/hdg_cordic_stage.sv
rtl/hdg_finish.sv
rtl/magnetometer_heading_atan2_top.sv
tb/magnetometer_heading_atan2_top_tb.sv
